/* design/floppy_data_separator_pll_core_macros.svh */
// Assertion macros for the data separator core
`ifndef FLOPPY_DATA_SEPARATOR_PLL_CORE_MACROS_SVH
`define FLOPPY_DATA_SEPARATOR_PLL_CORE_MACROS_SVH

`ifndef SYNTH
`define FDSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FDSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FDSP_ASSERT_IMPL(label, ante, cons)
`define FDSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/fdsp_pkg.sv */
package fdsp_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int POS_BITS   = 32;
    localparam int GAIN_SHIFT = 8;

    localparam int CELL_W    = 16;
    localparam int GAIN_W    = 9;
    localparam int MINR_W    = 9;
    localparam int MAXR_W    = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int TICKS_W  = 20;
    localparam int PERIOD_W = 17;
    localparam int PHASE_W  = 18;
    localparam int HIST_W   = 8;
    localparam int DELTA_W  = TICKS_W;
    localparam int PROD_W   = 38;
    localparam int DIVCNT_W = 6;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [1:0] OPC_TICK = 2'd0;
    localparam logic [1:0] OPC_FLUX = 2'd1;

    localparam logic [CELL_W-1:0] CELL_SIZE_RST   = 16'd12800;
    localparam logic [GAIN_W-1:0] PHASE_GAIN_RST  = 9'd166;
    localparam logic [GAIN_W-1:0] PERIOD_GAIN_RST = 9'd13;
    localparam logic [MINR_W-1:0] MIN_RATIO_RST   = 9'd192;
    localparam logic [MAXR_W-1:0] MAX_RATIO_RST   = 10'd320;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
    localparam logic [PHASE_W-1:0]  PHASE_MAX  = {1'b0, {(PHASE_W-1){1'b1}}};
    localparam logic [PHASE_W-1:0]  PHASE_MIN  = {1'b1, {(PHASE_W-1){1'b0}}};
    localparam logic [TICKS_W-1:0]  TICKS_MIN  = {1'b1, {(TICKS_W-1){1'b0}}};
    localparam logic [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE   = 3'd0,
        CFG_PHASE_GAIN  = 3'd1,
        CFG_PERIOD_GAIN = 3'd2,
        CFG_MIN_RATIO   = 3'd3,
        CFG_MAX_RATIO   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_FLUX,
        OP_RESTART
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [POS_BITS-1:0]   pos;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_size;
        logic [GAIN_W-1:0] phase_gain;
        logic [GAIN_W-1:0] period_gain;
        logic [MINR_W-1:0] min_ratio;
        logic [MAXR_W-1:0] max_ratio;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_BASE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_ADJ,
        ST_TICK
    } t_state;

endpackage

/* design/fdsp_front.sv */
module fdsp_front
    import fdsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic [POS_BITS-1:0] i_position,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output t_item               o_item
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    t_item                 w_item;
    logic                  w_push;
    logic                  w_pop;

    always_comb begin
        w_item.pos = i_position;
        if (i_opcode[1]) begin
            w_item.kind = OP_RESTART;
        end else if (i_opcode == OPC_FLUX) begin
            w_item.kind = OP_FLUX;
        end else begin
            w_item.kind = OP_TICK;
        end
    end

    assign o_in_ready   = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

/* design/fdsp_back.sv */
module fdsp_back
    import fdsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  t_item               i_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_data_bit,
    output logic [POS_BITS-1:0] o_bit_position
);

    t_state                      r_state, n_state;
    logic signed [TICKS_W-1:0]   r_ticks, n_ticks;
    logic [PERIOD_W-1:0]         r_period, n_period;
    logic signed [PHASE_W-1:0]   r_phase, n_phase;
    logic signed [HIST_W-1:0]    r_hist, n_hist;
    logic                        r_hit, n_hit;
    logic [POS_BITS-1:0]         r_pos, n_pos;
    logic signed [DELTA_W-1:0]   r_delta, n_delta;
    logic [PERIOD_W-1:0]         r_base, n_base;
    logic [PERIOD_W-1:0]         r_lo, n_lo;
    logic [PERIOD_W-1:0]         r_hi, n_hi;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic [PROD_W-1:0]           r_quo, n_quo;
    logic [PERIOD_W-1:0]         r_rem, n_rem;
    logic                        r_neg, n_neg;
    logic [DIVCNT_W-1:0]         r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_bit, n_out_bit;
    logic [POS_BITS-1:0]         r_out_pos, n_out_pos;

    logic                        w_slot_free;
    logic                        w_pop;
    logic [POS_BITS-1:0]         w_tick_pos;
    logic signed [TICKS_W:0]     w_tick_dec;
    logic signed [TICKS_W-1:0]   w_tick_sat;
    logic                        w_end;
    logic signed [TICKS_W-1:0]   w_reload;
    logic                        w_ticks_pos;
    logic signed [DELTA_W-1:0]   w_delta;
    logic signed [DELTA_W+9:0]   w_pprod;
    logic signed [DELTA_W+10:0]  w_prnd;
    logic signed [DELTA_W+2:0]   w_pshift;
    logic signed [PHASE_W-1:0]   w_psat;
    logic signed [HIST_W-1:0]    w_hist_new;
    logic                        w_hist_big;
    logic [CELL_W+GAIN_W-1:0]    w_base_prod;
    logic [CELL_W+MINR_W-1:0]    w_lo_prod;
    logic [CELL_W+MAXR_W-1:0]    w_hi_prod;
    logic signed [PROD_W-1:0]    w_prod;
    logic [PERIOD_W:0]           w_rem_sh;
    logic [PERIOD_W:0]           w_rem_diff;
    logic                        w_ge;
    logic signed [PROD_W:0]      w_step;
    logic signed [PROD_W+1:0]    w_sum;
    logic [PERIOD_W-1:0]         w_per_sat;
    logic [PERIOD_W-1:0]         w_per;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_pop       = i_item_valid && o_item_ready;

    // tick
    assign w_tick_pos = (r_state == ST_IDLE) ? i_item.pos : r_pos;
    assign w_tick_dec = {r_ticks[TICKS_W-1], r_ticks} - (TICKS_W+1)'(1 << FRAC_BITS);
    assign w_tick_sat = (w_tick_dec[TICKS_W] != w_tick_dec[TICKS_W-1]) ? TICKS_MIN
                                                                       : w_tick_dec[TICKS_W-1:0];
    assign w_end      = w_tick_sat[TICKS_W-1] || (w_tick_sat == '0);
    assign w_reload   = $signed({{(TICKS_W-PERIOD_W){1'b0}}, r_period})
                      + $signed({{(TICKS_W-PHASE_W){r_phase[PHASE_W-1]}}, r_phase});

    // phase
    assign w_ticks_pos = !r_ticks[TICKS_W-1] && (r_ticks != '0);
    assign w_delta  = $signed({{(DELTA_W-PERIOD_W+1){1'b0}}, r_period[PERIOD_W-1:1]}) - r_ticks;
    assign w_pprod  = $signed({1'b0, i_cfg.phase_gain}) * w_delta;
    assign w_prnd   = $signed({w_pprod[DELTA_W+9], w_pprod})
                    + $signed((DELTA_W+11)'(1 << (GAIN_SHIFT-1)));
    assign w_pshift = w_prnd[DELTA_W+10:GAIN_SHIFT];
    assign w_psat   = ((&w_pshift[DELTA_W+2:PHASE_W-1]) || !(|w_pshift[DELTA_W+2:PHASE_W-1]))
                    ? w_pshift[PHASE_W-1:0]
                    : (w_pshift[DELTA_W+2] ? PHASE_MIN : PHASE_MAX);

    always_comb begin
        if (w_delta[DELTA_W-1]) begin
            if (r_hist[HIST_W-1]) begin
                w_hist_new = (r_hist != HIST_MIN) ? r_hist - 8'sd1 : r_hist;
            end else begin
                w_hist_new = -8'sd1;
            end
        end else if (w_delta != '0) begin
            if (!r_hist[HIST_W-1] && (r_hist != '0)) begin
                w_hist_new = (r_hist != HIST_MAX) ? r_hist + 8'sd1 : r_hist;
            end else begin
                w_hist_new = 8'sd1;
            end
        end else begin
            w_hist_new = '0;
        end
    end
    assign w_hist_big = (w_hist_new >= 8'sd2) || (w_hist_new <= -8'sd2);

    // period adjust
    assign w_base_prod = i_cfg.cell_size * i_cfg.period_gain;
    assign w_lo_prod   = i_cfg.cell_size * i_cfg.min_ratio;
    assign w_hi_prod   = i_cfg.cell_size * i_cfg.max_ratio;
    assign w_prod      = $signed({1'b0, r_base}) * r_delta;

    assign w_rem_sh   = {r_rem, r_quo[PROD_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_period};
    assign w_ge       = (w_rem_sh >= {1'b0, r_period});

    always_comb begin
        if (r_quo == '0) begin
            w_step = r_hist[HIST_W-1] ? -(PROD_W+1)'(1) : (PROD_W+1)'(1);
        end else if (r_neg) begin
            w_step = -$signed({1'b0, r_quo});
        end else begin
            w_step = $signed({1'b0, r_quo});
        end
    end
    assign w_sum = $signed({{(PROD_W+2-PERIOD_W){1'b0}}, r_period})
                 + $signed({w_step[PROD_W], w_step});

    always_comb begin
        if (w_sum[PROD_W+1]) begin
            w_per_sat = '0;
        end else if (|w_sum[PROD_W:PERIOD_W]) begin
            w_per_sat = PERIOD_MAX;
        end else begin
            w_per_sat = w_sum[PERIOD_W-1:0];
        end
        if (w_per_sat < r_lo) begin
            w_per = r_lo;
        end else if (w_per_sat > r_hi) begin
            w_per = r_hi;
        end else begin
            w_per = w_per_sat;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop && (i_item.kind == OP_FLUX)) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                n_state = (w_ticks_pos && w_hist_big) ? ST_BASE : ST_TICK;
            end
            ST_BASE: n_state = ST_MUL;
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: begin
                n_state = (r_period == '0) ? ST_ADJ : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == DIVCNT_W'(PROD_W-1)) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ:  n_state = ST_TICK;
            ST_TICK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_item_ready = (r_state == ST_IDLE) && w_slot_free;
        n_ticks     = r_ticks;
        n_period    = r_period;
        n_phase     = r_phase;
        n_hist      = r_hist;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_delta     = r_delta;
        n_base      = r_base;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_bit   = r_out_bit;
        n_out_pos   = r_out_pos;

        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    n_pos = i_item.pos;
                    unique case (i_item.kind)
                        OP_RESTART: begin
                            n_ticks  = $signed({{(TICKS_W-CELL_W){1'b0}}, i_cfg.cell_size});
                            n_period = {{(PERIOD_W-CELL_W){1'b0}}, i_cfg.cell_size};
                            n_phase  = '0;
                            n_hist   = '0;
                            n_hit    = 1'b0;
                        end
                        OP_TICK: begin
                            n_ticks = w_end ? w_reload : w_tick_sat;
                            if (w_end) begin
                                n_out_valid = 1'b1;
                                n_out_bit   = r_hit;
                                n_out_pos   = w_tick_pos;
                                n_hit       = 1'b0;
                            end
                        end
                        OP_FLUX: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PHASE: begin
                if (!w_ticks_pos) begin
                    n_phase = '0;
                end else begin
                    n_delta = w_delta;
                    n_phase = w_psat;
                    n_hit   = 1'b1;
                    n_hist  = w_hist_new;
                end
            end
            ST_BASE: begin
                n_base = w_base_prod[CELL_W+GAIN_W-1:GAIN_SHIFT];
                n_lo   = w_lo_prod[CELL_W+MINR_W-1:GAIN_SHIFT];
                n_hi   = w_hi_prod[CELL_W+MAXR_W-1] ? PERIOD_MAX
                                                    : w_hi_prod[CELL_W+MAXR_W-2:GAIN_SHIFT];
            end
            ST_MUL: begin
                n_prod = w_prod;
            end
            ST_LOAD: begin
                n_neg = r_prod[PROD_W-1];
                n_quo = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
                n_rem = '0;
                n_cnt = '0;
                if (r_period == '0) begin
                    n_quo = '0;
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_rem_diff[PERIOD_W-1:0] : w_rem_sh[PERIOD_W-1:0];
                n_quo = {r_quo[PROD_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
            end
            ST_ADJ: begin
                n_period = w_per;
            end
            ST_TICK: begin
                n_ticks = w_end ? w_reload : w_tick_sat;
                if (w_end) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_hit;
                    n_out_pos   = w_tick_pos;
                    n_hit       = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ticks     <= $signed({{(TICKS_W-CELL_W){1'b0}}, CELL_SIZE_RST});
            r_period    <= {{(PERIOD_W-CELL_W){1'b0}}, CELL_SIZE_RST};
            r_phase     <= '0;
            r_hist      <= '0;
            r_hit       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ticks     <= n_ticks;
            r_period    <= n_period;
            r_phase     <= n_phase;
            r_hist      <= n_hist;
            r_hit       <= n_hit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_delta   <= n_delta;
        r_base    <= n_base;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_prod    <= n_prod;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_out_bit <= n_out_bit;
        r_out_pos <= n_out_pos;
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_bit     = r_out_bit;
    assign o_bit_position = r_out_pos;

endmodule

/* design/floppy_data_separator_pll_core.sv */
// Digital PLL data separator for floppy flux samples. Each input transaction is one sample
// tick (plain, ending a flux interval with a transition, or restart) and yields at most one
// recovered bit with the position tag of the tick that closed its window. Ticks enter a
// two-entry queue and the loop engine drains it: a plain tick or restart is done on pop,
// a transition passes the phase and tick states, and one that adjusts the period also
// passes base, mul, load, a 38-step radix-2 divide forming the period step, and adjust.
// It pulls ticks only when the output register is free or being emptied. Config is read
// live; the user must use the write port only while the core is idle; this is unchecked.
`include "floppy_data_separator_pll_core_macros.svh"

module floppy_data_separator_pll_core
    import fdsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [POS_BITS-1:0]  i_position,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_data_bit,
    output logic [POS_BITS-1:0]  o_bit_position
);

    t_cfg  r_cfg;
    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;
    logic  w_item_pop;

    assign w_item_pop = w_item_valid && w_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_size   <= CELL_SIZE_RST;
            r_cfg.phase_gain  <= PHASE_GAIN_RST;
            r_cfg.period_gain <= PERIOD_GAIN_RST;
            r_cfg.min_ratio   <= MIN_RATIO_RST;
            r_cfg.max_ratio   <= MAX_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CELL_SIZE:   r_cfg.cell_size   <= i_cfg_data[CELL_W-1:0];
                CFG_PHASE_GAIN:  r_cfg.phase_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_PERIOD_GAIN: r_cfg.period_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MIN_RATIO:   r_cfg.min_ratio   <= i_cfg_data[MINR_W-1:0];
                CFG_MAX_RATIO:   r_cfg.max_ratio   <= i_cfg_data[MAXR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fdsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    fdsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (w_item_valid),
        .o_item_ready   (w_item_ready),
        .i_item         (w_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_bit     (o_data_bit),
        .o_bit_position (o_bit_position)
    );

    `FDSP_ASSERT_IMPL(a_pop_has_room, w_item_pop, !o_out_valid || i_out_ready)
    `FDSP_ASSERT_NEXT(a_push_queued, i_in_valid && o_in_ready, w_item_valid)
    `FDSP_ASSERT_NEXT(a_restart_silent, w_item_pop && (w_item.kind == OP_RESTART), !o_out_valid)

endmodule
